### src/pchm_pkg.sv
package pchm_pkg;

    typedef enum logic [1:0] {
        OP_LOOKUP = 2'd0,
        OP_INSERT = 2'd1,
        OP_REMOVE = 2'd2
    } op_code_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_SPACE = 2'd1,
        ST_NOT_FOUND = 2'd2
    } status_code_t;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] key;
        logic [31:0] value;
    } in_word_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        found;
        logic [31:0] value_out;
    } out_word_t;

    typedef struct packed {
        logic         clr;
        logic         capture;
        logic         rd_head;
        logic         ld_head;
        logic         rd_node;
        logic         step;
        logic         rd_free;
        logic         alloc;
        logic         wr_val;
        logic         unlink;
        logic         push;
        logic         set_res;
        status_code_t res_status;
        logic         res_found;
        logic         emit;
    } ctl_cmd_t;

    typedef struct packed {
        logic       clr_done;
        logic       cur_null;
        logic       key_match;
        logic       free_null;
        logic       out_busy;
        logic [1:0] op;
    } ctl_sts_t;

endpackage

### src/pchm_ctrl.sv
module pchm_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  pchm_pkg::ctl_sts_t sts,
    output pchm_pkg::ctl_cmd_t cmd
);
    import pchm_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_HEAD_RD,
        S_HEAD_LD,
        S_NODE_RD,
        S_NODE_CMP,
        S_ALLOC,
        S_UNLINK,
        S_PUSH,
        S_RESP
    } state_t;

    state_t state_reg, state_next;
    logic   is_ins;
    logic   is_rem;

    assign is_ins  = (sts.op == OP_INSERT);
    assign is_rem  = (sts.op == OP_REMOVE);
    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        cmd        = '0;
        cmd.res_status = ST_OK;
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR: begin
                cmd.clr = 1'b1;
                if (sts.clr_done) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = S_HEAD_RD;
                end
            end
            S_HEAD_RD: begin
                cmd.rd_head = 1'b1;
                state_next  = S_HEAD_LD;
            end
            S_HEAD_LD: begin
                cmd.ld_head = 1'b1;
                state_next  = S_NODE_RD;
            end
            S_NODE_RD: begin
                if (!sts.cur_null) begin
                    cmd.rd_node = 1'b1;
                    state_next  = S_NODE_CMP;
                end else if (is_ins && !sts.free_null) begin
                    cmd.rd_free = 1'b1;
                    state_next  = S_ALLOC;
                end else begin
                    cmd.set_res    = 1'b1;
                    cmd.res_status = is_ins ? ST_NO_SPACE : ST_NOT_FOUND;
                    state_next     = S_RESP;
                end
            end
            S_NODE_CMP: begin
                if (!sts.key_match) begin
                    cmd.step   = 1'b1;
                    state_next = S_NODE_RD;
                end else if (is_rem) begin
                    cmd.unlink = 1'b1;
                    state_next = S_PUSH;
                end else begin
                    cmd.wr_val    = is_ins;
                    cmd.set_res   = 1'b1;
                    cmd.res_found = !is_ins;
                    state_next    = S_RESP;
                end
            end
            S_ALLOC: begin
                cmd.alloc   = 1'b1;
                cmd.set_res = 1'b1;
                state_next  = S_RESP;
            end
            S_UNLINK: begin
                state_next = S_PUSH;
            end
            S_PUSH: begin
                cmd.push    = 1'b1;
                cmd.set_res = 1'b1;
                state_next  = S_RESP;
            end
            S_RESP: begin
                if (!sts.out_busy) begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> !sts.out_busy)
        else $error("result emitted over a pending word");
    a_alloc_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.alloc |-> !sts.free_null)
        else $error("allocation from an empty pool");
    a_unlink_push: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.unlink |=> cmd.push)
        else $error("unlinked node not returned to pool");

endmodule

### src/pchm_datapath.sv
module pchm_datapath #(
    parameter int ENTRIES    = 256,
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  pchm_pkg::in_word_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output pchm_pkg::out_word_t m_data,
    input  pchm_pkg::ctl_cmd_t  cmd,
    output pchm_pkg::ctl_sts_t  sts
);
    import pchm_pkg::*;

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int PW = IW + 1;
    localparam logic [PW-1:0] NULL_PTR = PW'(ENTRIES);

    logic [PW-1:0]         bucket_head [ENTRIES];
    logic [PW-1:0]         next_link   [ENTRIES];
    logic [KEY_BITS-1:0]   key_store   [ENTRIES];
    logic [VALUE_BITS-1:0] value_store [ENTRIES];

    logic [1:0]            op_reg;
    logic [KEY_BITS-1:0]   key_reg;
    logic [VALUE_BITS-1:0] val_reg;
    logic [IW-1:0]         bucket_reg;
    logic [IW-1:0]         clr_idx_reg;
    logic [PW-1:0]         head_rd_reg, head_q_reg, link_rd_reg;
    logic [PW-1:0]         cur_reg, prev_reg, free_head_reg;
    logic [KEY_BITS-1:0]   key_rd_reg;
    logic [VALUE_BITS-1:0] val_rd_reg;
    out_word_t             res_reg;
    out_word_t             m_data_reg;
    logic                  m_valid_reg;

    logic [KEY_BITS-1:0]      key_in;
    logic [KEY_BITS+IW-1:0]   key_ext;
    logic [IW:0]              low_bits;
    logic [IW-1:0]            bucket_in;
    logic [IW-1:0]            cur_idx, prev_idx, free_idx;

    assign key_in    = KEY_BITS'(s_data.key);
    assign key_ext   = {{IW{1'b0}}, key_in};
    assign low_bits  = {1'b0, key_ext[IW-1:0]};
    assign bucket_in = (low_bits >= (IW+1)'(ENTRIES)) ?
                       IW'(low_bits - (IW+1)'(ENTRIES)) : low_bits[IW-1:0];
    assign cur_idx   = cur_reg[IW-1:0];
    assign prev_idx  = prev_reg[IW-1:0];
    assign free_idx  = free_head_reg[IW-1:0];

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg     <= s_data.op;
            key_reg    <= key_in;
            val_reg    <= VALUE_BITS'(s_data.value);
            bucket_reg <= bucket_in;
        end
        if (cmd.ld_head) begin
            head_q_reg <= head_rd_reg;
        end
    end

    // bucket heads
    always_ff @(posedge aclk) begin
        if (cmd.clr) begin
            bucket_head[clr_idx_reg] <= NULL_PTR;
        end else if (cmd.alloc) begin
            bucket_head[bucket_reg] <= free_head_reg;
        end else if (cmd.unlink && prev_reg == NULL_PTR) begin
            bucket_head[bucket_reg] <= link_rd_reg;
        end
        if (cmd.rd_head) begin
            head_rd_reg <= bucket_head[bucket_reg];
        end
    end

    // chain and free links
    always_ff @(posedge aclk) begin
        if (cmd.clr) begin
            next_link[clr_idx_reg] <= (clr_idx_reg == '0) ? NULL_PTR :
                                      PW'(clr_idx_reg) - PW'(1);
        end else if (cmd.alloc) begin
            next_link[free_idx] <= head_q_reg;
        end else if (cmd.unlink && prev_reg != NULL_PTR) begin
            next_link[prev_idx] <= link_rd_reg;
        end else if (cmd.push) begin
            next_link[cur_idx] <= free_head_reg;
        end
        if (cmd.rd_free) begin
            link_rd_reg <= next_link[free_idx];
        end else if (cmd.rd_node) begin
            link_rd_reg <= next_link[cur_idx];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.alloc) begin
            key_store[free_idx] <= key_reg;
        end
        if (cmd.rd_node) begin
            key_rd_reg <= key_store[cur_idx];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.alloc) begin
            value_store[free_idx] <= val_reg;
        end else if (cmd.wr_val) begin
            value_store[cur_idx] <= val_reg;
        end
        if (cmd.rd_node) begin
            val_rd_reg <= value_store[cur_idx];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.ld_head) begin
            cur_reg  <= head_rd_reg;
            prev_reg <= NULL_PTR;
        end else if (cmd.step) begin
            cur_reg  <= link_rd_reg;
            prev_reg <= cur_reg;
        end
        if (cmd.set_res) begin
            res_reg.status    <= cmd.res_status;
            res_reg.found     <= cmd.res_found;
            res_reg.value_out <= cmd.res_found ? 32'(val_rd_reg) : 32'd0;
        end
        if (cmd.emit) begin
            m_data_reg <= res_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_idx_reg   <= '0;
            free_head_reg <= PW'(ENTRIES - 1);
            m_valid_reg   <= 1'b0;
        end else begin
            if (cmd.clr) begin
                clr_idx_reg <= clr_idx_reg + IW'(1);
            end
            if (cmd.alloc) begin
                free_head_reg <= link_rd_reg;
            end else if (cmd.push) begin
                free_head_reg <= cur_reg;
            end
            if (cmd.emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign sts.clr_done  = (clr_idx_reg == IW'(ENTRIES - 1));
    assign sts.cur_null  = (cur_reg == NULL_PTR);
    assign sts.key_match = (key_rd_reg == key_reg);
    assign sts.free_null = (free_head_reg == NULL_PTR);
    assign sts.out_busy  = m_valid_reg && !m_ready;
    assign sts.op        = op_reg;

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

### src/pooled_chained_hash_map_core.sv
// pooled chained hash map: fixed pool of ENTRIES key/value nodes
// input channel s_valid/s_ready/s_data carries op, key, value
// op lookup returns found and value, insert adds or overwrites,
// remove unlinks the key and returns its node to the free pool
// result channel m_valid/m_ready/m_data carries status, found, value_out,
// one word per request
// one request is processed at a time; after acceptance the controller
// reads and loads the bucket head, then for each chain node reads the node and
// compares its key; a successful remove adds a push step and an insert
// that links a new node adds an alloc step before the result is set
// the chain walk, a node read and key compare per node, sets how long it takes
// after reset a clearing pass sets all bucket heads to empty and rebuilds
// the free list, with s_ready low
// a finished result sits in the output register; the next request is
// accepted meanwhile, and its result waits while m_ready stays low
module pooled_chained_hash_map_core #(
    parameter int ENTRIES    = 256,
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  pchm_pkg::in_word_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output pchm_pkg::out_word_t m_data
);
    import pchm_pkg::*;

    ctl_cmd_t cmd;
    ctl_sts_t sts;

    pchm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    pchm_datapath #(
        .ENTRIES    (ENTRIES),
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .cmd     (cmd),
        .sts     (sts)
    );

endmodule

### dv/testbench.sv
module testbench;
    import pchm_pkg::*;

    localparam int ENTRIES  = 256;
    localparam int NIL      = ENTRIES;
    localparam int WD_LIMIT = 20000;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_word_t  s_data;
    logic      m_valid;
    logic      m_ready;
    out_word_t m_data;

    pooled_chained_hash_map_core #(
        .ENTRIES(ENTRIES), .KEY_BITS(32), .VALUE_BITS(32)
    ) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    // map mirror
    int          head_of[ENTRIES];
    int          link_of[ENTRIES];
    logic [31:0] key_of[ENTRIES];
    logic [31:0] val_of[ENTRIES];
    int          free_top;

    in_word_t  pending_words[$];
    out_word_t expected_results[$];
    int        errors;
    int        accepted_in;
    int        accepted_out;
    int        quiet_cycles;
    bit        calm;
    int        n_found;
    int        n_full;

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    function automatic out_word_t map_apply(in_word_t w);
        out_word_t r;
        int b, cur, prev, hit, steps, n;
        r = '0;
        b = w.key % ENTRIES;
        cur = head_of[b];
        prev = NIL;
        hit = NIL;
        steps = 0;
        while (cur < NIL && steps < ENTRIES) begin
            if (key_of[cur] == w.key) begin
                hit = cur;
                break;
            end
            prev = cur;
            cur = link_of[cur];
            steps++;
        end
        if (hit == NIL) prev = NIL;
        if (w.op == OP_INSERT) begin
            if (hit < NIL) begin
                val_of[hit] = w.value;
            end else if (free_top >= NIL) begin
                r.status = ST_NO_SPACE;
            end else begin
                n = free_top;
                free_top = link_of[n];
                link_of[n] = head_of[b];
                head_of[b] = n;
                key_of[n] = w.key;
                val_of[n] = w.value;
            end
        end else if (w.op == OP_REMOVE) begin
            if (hit < NIL) begin
                if (prev < NIL) link_of[prev] = link_of[hit];
                else head_of[b] = link_of[hit];
                link_of[hit] = free_top;
                free_top = hit;
            end else begin
                r.status = ST_NOT_FOUND;
            end
        end else begin
            if (hit < NIL) begin
                r.found = 1'b1;
                r.value_out = val_of[hit];
            end else begin
                r.status = ST_NOT_FOUND;
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, out_word_t got, out_word_t want);
        $display("error %s: got st=%0d f=%0d v=%h want st=%0d f=%0d v=%h", what,
                 got.status, got.found, got.value_out,
                 want.status, want.found, want.value_out);
        errors++;
    endtask

    function automatic in_word_t mk(logic [1:0] op, logic [31:0] k, logic [31:0] v);
        in_word_t w;
        w.op = op;
        w.key = k;
        w.value = v;
        return w;
    endfunction

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_data  <= '0;
        end else if (!s_valid || s_ready) begin
            if (s_valid) begin
                expected_results.push_back(map_apply(s_data));
                accepted_in++;
            end
            if (pending_words.size() > 0 && (calm || $urandom_range(99) >= 13)) begin
                s_valid <= 1'b1;
                s_data  <= pending_words.pop_front();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                accepted_out++;
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected word", m_data, '0);
                end else begin
                    out_word_t e;
                    e = expected_results.pop_front();
                    if (m_data.status != e.status || m_data.found != e.found ||
                        m_data.value_out != e.value_out)
                        report_mismatch("field", m_data, e);
                    if (e.found) n_found++;
                    if (e.status == ST_NO_SPACE) n_full++;
                end
            end
            m_ready <= calm || $urandom_range(99) >= 13;
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WD_LIMIT) begin
                $display("pooled_chained_hash_map_core: mismatch");
                $finish;
            end
        end
    end

    initial begin
        logic [31:0] keys[$];
        logic [31:0] k;
        int r, i;
        errors = 0; accepted_in = 0; accepted_out = 0; quiet_cycles = 0;
        n_found = 0; n_full = 0; calm = 1'b0;
        s_valid = 1'b0; s_data = '0; m_ready = 1'b0;
        for (i = 0; i < ENTRIES; i++) begin
            head_of[i] = NIL;
            link_of[i] = (i == 0) ? NIL : i - 1;
            key_of[i] = '0;
            val_of[i] = '0;
        end
        free_top = ENTRIES - 1;
        aresetn = 1'b0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: empty map, extremes, chains in one bucket, op code 3
        pending_words.push_back(mk(OP_LOOKUP, 32'h0, 32'h0));
        pending_words.push_back(mk(OP_REMOVE, 32'hffffffff, 32'h0));
        pending_words.push_back(mk(OP_INSERT, 32'h0, 32'hffffffff));
        pending_words.push_back(mk(OP_INSERT, 32'hffffffff, 32'h0));
        pending_words.push_back(mk(OP_INSERT, 32'h100, 32'haaaa5555));
        pending_words.push_back(mk(OP_INSERT, 32'h200, 32'h5555aaaa));
        pending_words.push_back(mk(OP_LOOKUP, 32'h0, 32'h0));
        pending_words.push_back(mk(OP_LOOKUP, 32'h100, 32'h0));
        pending_words.push_back(mk(2'd3, 32'h200, 32'hffffffff));
        pending_words.push_back(mk(OP_INSERT, 32'h100, 32'h12345678));
        pending_words.push_back(mk(OP_LOOKUP, 32'h300, 32'h0));
        pending_words.push_back(mk(OP_REMOVE, 32'h100, 32'h0));
        pending_words.push_back(mk(OP_LOOKUP, 32'h100, 32'h0));
        pending_words.push_back(mk(OP_REMOVE, 32'h0, 32'h0));
        pending_words.push_back(mk(OP_LOOKUP, 32'h200, 32'h0));
        pending_words.push_back(mk(OP_REMOVE, 32'h200, 32'h0));
        pending_words.push_back(mk(OP_LOOKUP, 32'hffffffff, 32'h0));
        keys.push_back(32'hffffffff);

        // random: keys drawn mostly from a live pool, some buckets crowded
        for (i = 0; pending_words.size() < 1250; i++) begin
            r = $urandom_range(99);
            if (keys.size() > 0 && r < 55)
                k = keys[$urandom_range(keys.size() - 1)];
            else if (r < 75)
                k = {20'd0, 4'($urandom_range(15)), 8'($urandom_range(3))} |
                    ($urandom() & 32'hff000000);
            else
                k = $urandom();
            r = $urandom_range(99);
            if (i >= 400 && i < 700) begin
                // fill phase: drive the pool empty
                pending_words.push_back(mk(r < 80 ? OP_INSERT : OP_LOOKUP, $urandom(), $urandom()));
            end else if (r < 40) begin
                pending_words.push_back(mk(OP_INSERT, k, $urandom()));
                if (keys.size() < 300) keys.push_back(k);
            end else if (r < 70) begin
                pending_words.push_back(mk(OP_REMOVE, k, $urandom()));
            end else begin
                pending_words.push_back(mk(2'($urandom_range(3) == 3 ? 3 : 0), k, $urandom()));
            end
            if (i == 900) begin
                // free pool nodes by removing every key held in the keys list
                for (int j = 0; j < keys.size(); j++)
                    pending_words.push_back(mk(OP_REMOVE, keys[j], 32'h0));
            end
        end

        while (pending_words.size() > 400) @(posedge aclk);
        calm = 1'b1;
        while (pending_words.size() > 100) @(posedge aclk);
        calm = 1'b0;
        while (pending_words.size() > 0 || s_valid || expected_results.size() > 0)
            @(posedge aclk);
        repeat (50) @(posedge aclk);
        $display("covered %0d requests and %0d results, %0d hits, %0d pool-full inserts",
                 accepted_in, accepted_out, n_found, n_full);
        if (errors == 0 && expected_results.size() == 0) begin
            $display("pooled_chained_hash_map_core: match");
        end else begin
            $display("pooled_chained_hash_map_core: mismatch");
        end
        $finish;
    end
endmodule

### sim.f
src/pchm_pkg.sv
src/pchm_ctrl.sv
src/pchm_datapath.sv
src/pooled_chained_hash_map_core.sv
dv/testbench.sv
